FILE: design/aed_pkg.sv
// aed_pkg: widths, constants, register indexes and shared types of the
// audio envelope detector; used by every other file of the block
`default_nettype none

package aed_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ENV_W      = 16;
  localparam int COEF_W     = 16;
  localparam int LEVEL_W    = 17;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_W      = 21;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int FRAC_W     = 16;
  localparam int SHIFT_W    = 4;
  localparam int MAGL_W     = SHIFT_W + FRAC_W;
  localparam int CNT_W      = 4;
  localparam int DB_SHIFT   = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG     = 2'd3;

  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;

  localparam logic [ENV_W-1:0]          ENV_ONE     = 16'h8000;
  localparam logic signed [LEVEL_W-1:0] DB_FLOOR    = -17'sd24576;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX   = 17'sd32768;
  localparam logic [MUL_W-1:0]          DB_PER_LOG2 = 21'd394566;
  localparam logic [PROD_W-1:0]         DB_ROUND    = PROD_W'(1) << (DB_SHIFT - 1);
  localparam logic [CNT_W-1:0]          CNT_LAST    = CNT_W'(FRAC_W - 1);

  typedef struct packed {
    logic [COEF_W-1:0] attack_coef;
    logic [COEF_W-1:0] release_coef;
    logic [MODE_W-1:0] detect_mode;
    logic              log_output;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic sq;
    logic smooth;
    logic env;
    logic norm;
    logic step;
    logic mag;
    logic scale;
    logic out_load;
  } dp_cmd_t;

endpackage

`default_nettype wire

FILE: design/aed_in_if.sv
// aed_in_if: sample request channel (valid, ready, sample)
// depends on aed_pkg for the sample width
`default_nettype none

interface aed_in_if import aed_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: design/aed_out_if.sv
// aed_out_if: level request channel (valid, ready, level)
// depends on aed_pkg for the level width
`default_nettype none

interface aed_out_if import aed_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

FILE: design/aed_ctrl.sv
// aed_ctrl: sequencer of the envelope detector, drives datapath commands
// and both handshakes; depends on aed_pkg
`default_nettype none

module aed_ctrl import aed_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQ   = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ENV  = 4'd3;
  localparam logic [3:0] S_NORM = 4'd4;
  localparam logic [3:0] S_LOG  = 4'd5;
  localparam logic [3:0] S_MAG  = 4'd6;
  localparam logic [3:0] S_SCL  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (cfg.detect_mode == MODE_SQUARE) ? S_SQ : S_MUL;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.smooth = 1'b1;
        state_nxt  = S_ENV;
      end
      S_ENV: begin
        cmd.env   = 1'b1;
        state_nxt = cfg.log_output ? S_NORM : S_OUT;
      end
      S_NORM: begin
        cmd.norm  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_LOG;
      end
      S_LOG: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        cmd.mag   = 1'b1;
        state_nxt = S_SCL;
      end
      S_SCL: begin
        cmd.scale = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: design/aed_dp.sv
// aed_dp: rectifier, shared multiplier, smoother, log2 by squaring and
// output register of the envelope detector; depends on aed_pkg
`default_nettype none

module aed_dp import aed_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  dp_cmd_t                    cmd,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [LEVEL_W-1:0]  level
);

  logic [ENV_W-1:0]          a_r, y_r, env_r, env_nxt;
  logic [FRAC_W-1:0]         frac_r;
  logic [SHIFT_W-1:0]        k_r, lz;
  logic [MAGL_W-1:0]         magl_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [LEVEL_W-1:0] level_r, level_nxt;

  logic [SAMPLE_W-1:0]       sample_u, mag;
  logic [SAMPLE_W+ENV_W-1:0] scaled;
  logic [ENV_W-1:0]          rect;
  logic [COEF_W-1:0]         coef;
  logic signed [ENV_W:0]     diff;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod, sum;
  logic [ENV_W:0]            sum_env, sq_t;
  logic [PROD_W-1:0]         rounded;
  logic [ENV_W-1:0]          q;
  logic signed [LEVEL_W-1:0] db;

  // magnitude brought to Q1.15
  assign sample_u = unsigned'(sample);
  assign mag      = sample[SAMPLE_W-1] ? (~sample_u + 1'b1) : sample_u;
  assign scaled   = {mag, {ENV_W{1'b0}}};
  assign rect     = scaled[SAMPLE_W+ENV_W-1 -: ENV_W];

  assign coef = (a_r > env_r) ? cfg.attack_coef : cfg.release_coef;
  assign diff = signed'({1'b0, env_r}) - signed'({1'b0, a_r});

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.sq) begin
      mul_a = MUL_W'(a_r);
      mul_b = MUL_W'(a_r);
    end else if (cmd.smooth) begin
      mul_a = MUL_W'(coef);
      mul_b = MUL_W'(diff);
    end else if (cmd.step) begin
      mul_a = MUL_W'(y_r);
      mul_b = MUL_W'(y_r);
    end else if (cmd.scale) begin
      mul_a = MUL_W'(magl_r);
      mul_b = DB_PER_LOG2;
    end
  end

  assign prod = mul_a * mul_b;

  // c*(env-a) + a*2^16, then >>16 and clamp
  assign sum     = prod_r + signed'(PROD_W'({a_r, {COEF_W{1'b0}}}));
  assign sum_env = sum[ENV_W+COEF_W:COEF_W];
  assign env_nxt = (sum_env > {1'b0, ENV_ONE}) ? ENV_ONE : sum_env[ENV_W-1:0];

  always_comb begin
    lz = '0;
    for (int i = 0; i < ENV_W; i++) begin
      if (env_r[i]) begin
        lz = SHIFT_W'(ENV_W - 1 - i);
      end
    end
  end

  assign sq_t = prod[2*ENV_W-1:ENV_W-1];

  assign rounded = unsigned'(prod_r) + DB_ROUND;
  assign q       = rounded[DB_SHIFT+ENV_W-1:DB_SHIFT];
  assign db      = -signed'({1'b0, q});

  always_comb begin
    if (!cfg.log_output) begin
      level_nxt = signed'({1'b0, env_r});
    end else if (env_r == '0) begin
      level_nxt = DB_FLOOR;
    end else begin
      level_nxt = db;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (cmd.env) begin
      env_r <= env_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= rect;
    end else if (cmd.sq) begin
      a_r <= prod[2*ENV_W-2:ENV_W-1];
    end
    if (cmd.smooth || cmd.scale) begin
      prod_r <= prod;
    end
    if (cmd.norm) begin
      k_r    <= lz;
      y_r    <= env_r << lz;
      frac_r <= '0;
    end else if (cmd.step) begin
      y_r    <= sq_t[ENV_W] ? sq_t[ENV_W:1] : sq_t[ENV_W-1:0];
      frac_r <= {frac_r[FRAC_W-2:0], sq_t[ENV_W]};
    end
    if (cmd.mag) begin
      magl_r <= {k_r, {FRAC_W{1'b0}}} - MAGL_W'(frac_r);
    end
    if (cmd.out_load) begin
      level_r <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

`default_nettype wire

FILE: design/audio_envelope_detector.sv
// audio_envelope_detector: top level, configuration registers, controller
// and datapath; depends on aed_pkg, aed_in_if, aed_out_if, aed_ctrl, aed_dp
//
//   port       dir  request          width
//   in_chan    in   sample           16 signed, Q1.15
//   out_chan   out  level            17 signed, Q1.15 or dB Q8.8
//   cfg_*      in   register write   2-bit index, 16-bit data
//
// linear output: each accepted sample is rectified (and squared in square mode),
// smoothed on the shared multiplier and clamped into the envelope register
// log output: the envelope is then normalised and its log2 fraction taken
// by 16 squaring steps on the one shared multiplier, then scaled to dB
// one request at a time; a finished result waits in the output register
// while the next sample is taken; reset is synchronous, clears envelope
`default_nettype none

module audio_envelope_detector import aed_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  aed_in_if.sink                in_chan,
  aed_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  dp_cmd_t cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ATTACK:  cfg_nxt.attack_coef  = cfg_wdata[COEF_W-1:0];
        CFG_RELEASE: cfg_nxt.release_coef = cfg_wdata[COEF_W-1:0];
        CFG_MODE:    cfg_nxt.detect_mode  = cfg_wdata[MODE_W-1:0];
        CFG_LOG:     cfg_nxt.log_output   = cfg_wdata[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  aed_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  aed_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .cmd    (cmd),
    .sample (in_chan.sample),
    .level  (out_chan.level)
  );

  // one sample in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("ready held after sample accepted");

  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> in_chan.ready)
    else $error("result raised while sequencer busy");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.level >= DB_FLOOR && out_chan.level <= LEVEL_MAX))
    else $error("level out of range");

endmodule

`default_nettype wire

FILE: tb/audio_envelope_detector_tb.sv
`timescale 1ns / 100ps
// audio_envelope_detector_tb: drives samples and register writes into the envelope
// detector and compares each level with a listed value or an attack/release tracker here
// depends on aed_pkg, aed_in_if, aed_out_if and audio_envelope_detector

module audio_envelope_detector_tb import aed_pkg::*; ();

  localparam logic [MODE_W-1:0] MODE_PEAK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ROOT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ABS  = 2'd3;
  localparam int N_PHASES      = 12;
  localparam int PHASE_SAMPLES = 75;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;

  typedef struct {
    cfg_t                       cfg;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         known;
    logic signed [LEVEL_W-1:0]  level;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  aed_in_if  in_chan ();
  aed_out_if out_chan ();

  audio_envelope_detector i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t                       held_cfg;
  longint unsigned            held_env;
  logic signed [LEVEL_W-1:0]  pending_levels[$];
  logic signed [LEVEL_W-1:0]  want_level;
  stim_row_t                  directed_rows[$];
  logic signed [SAMPLE_W-1:0] last_sample;
  int                         fault_count;
  bit                         idle_en;
  bit                         hold_req;
  bit                         hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("audio_envelope_detector_tb failed");
    $finish;
  end

  // rectify (and square in square mode), smooth and clamp one sample, then give linear or dB level
  function automatic logic signed [LEVEL_W-1:0] track_envelope(
    input logic signed [SAMPLE_W-1:0] s
  );
    longint unsigned a, c, acc, env, y, mag_l, q;
    int              p;
    int unsigned     frac;
    a = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    if (SAMPLE_W >= 16) a = a >> (SAMPLE_W - 16);
    else a = a << (16 - SAMPLE_W);
    if (held_cfg.detect_mode == MODE_SQUARE) a = (a * a) >> 15;
    c = (a > held_env) ? held_cfg.attack_coef : held_cfg.release_coef;
    acc = c * held_env + (64'd65536 - c) * a;
    env = acc >> 16;
    if (env > ENV_ONE) env = ENV_ONE;
    held_env = env;
    if (!held_cfg.log_output) return LEVEL_W'(env);
    if (env == 0) return DB_FLOOR;
    p = 0;
    for (int i = 0; i < 17; i++) if (env[i]) p = i;
    y = (p >= 15) ? env >> (p - 15) : env << (15 - p);
    frac = 0;
    for (int i = 0; i < FRAC_W; i++) begin
      y = (y * y) >> 15;
      frac = frac << 1;
      if (y >= 65536) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    if (p >= 15) return '0;
    mag_l = longint'(15 - p) * 65536 - frac;
    q = (mag_l * DB_PER_LOG2 + (64'd1 << (DB_SHIFT - 1))) >> DB_SHIFT;
    return -LEVEL_W'(q);
  endfunction

  function automatic void add_row(
    input logic [COEF_W-1:0] atk,
    input logic [COEF_W-1:0] rel,
    input logic [MODE_W-1:0] mode,
    input logic              lg,
    input int                smp,
    input bit                known,
    input int                lvl
  );
    stim_row_t r;
    r.cfg.attack_coef  = atk;
    r.cfg.release_coef = rel;
    r.cfg.detect_mode  = mode;
    r.cfg.log_output   = lg;
    r.sample           = SAMPLE_W'(smp);
    r.known            = known;
    r.level            = LEVEL_W'(lvl);
    directed_rows.push_back(r);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return COEF_W'($urandom);
      3: return COEF_W'(16'hFFFF - $urandom_range(0, 4095));
      default: return COEF_W'($urandom_range(0, 255) << 8);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: s = {1'b1, {(SAMPLE_W-1){1'b0}}};
          1: s = {1'b0, {(SAMPLE_W-1){1'b1}}};
          2: s = '0;
          default: s = '1;
        endcase
      end
      1, 2, 3, 4: s = SAMPLE_W'($urandom);
      5, 6, 7: s = $signed(SAMPLE_W'($urandom)) >>> $urandom_range(1, SAMPLE_W - 1);
      default: s = -last_sample;
    endcase
    last_sample = s;
    return s;
  endfunction

  // registers change only once every level has come back
  task automatic write_settings(input cfg_t s);
    logic [CFG_DATA_W-1:0] wd;
    in_chan.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ATTACK;
    cfg_wdata <= s.attack_coef;
    @(posedge clk);
    cfg_idx   <= CFG_RELEASE;
    cfg_wdata <= s.release_coef;
    @(posedge clk);
    wd = CFG_DATA_W'($urandom);
    wd[MODE_W-1:0] = s.detect_mode;
    cfg_idx   <= CFG_MODE;
    cfg_wdata <= wd;
    @(posedge clk);
    wd = CFG_DATA_W'($urandom);
    wd[0] = s.log_output;
    cfg_idx   <= CFG_LOG;
    cfg_wdata <= wd;
    @(posedge clk);
    cfg_we <= 1'b0;
    held_cfg = s;
  endtask

  task automatic send_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input bit                         known,
    input logic signed [LEVEL_W-1:0]  level
  );
    logic signed [LEVEL_W-1:0] lvl;
    in_chan.valid  <= 1'b1;
    in_chan.sample <= s;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    lvl = track_envelope(s);
    pending_levels.push_back(known ? level : lvl);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // level sink: random stalls, one long hold-off
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_levels.size() == 0) begin
        if (fault_count < 10) $display("unexpected level %0d", out_chan.level);
        fault_count++;
      end else begin
        want_level = pending_levels.pop_front();
        if (out_chan.level !== want_level) begin
          if (fault_count < 10)
            $display("level mismatch: expected %0d, got %0d", want_level, out_chan.level);
          fault_count++;
        end
      end
    end
  end

  initial begin
    cfg_t s;
    fault_count    = 0;
    idle_en        = 1'b1;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    last_sample    = '0;
    held_cfg       = '0;
    held_env       = 0;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_ATTACK;
    cfg_wdata      <= '0;
    in_chan.valid  <= 1'b0;
    in_chan.sample <= '0;

    // zero coefficients: envelope jumps straight to the rectified (in square mode squared) value
    add_row(0, 0, MODE_PEAK, 1'b0, 0, 1, 0);
    add_row(0, 0, MODE_PEAK, 1'b0, 32767, 1, 32767);
    add_row(0, 0, MODE_PEAK, 1'b0, -32768, 1, ENV_ONE);
    add_row(0, 0, MODE_PEAK, 1'b0, -1, 1, 1);
    add_row(0, 0, MODE_PEAK, 1'b0, -32767, 1, 32767);
    add_row(0, 0, MODE_PEAK, 1'b1, 0, 1, DB_FLOOR);
    add_row(0, 0, MODE_PEAK, 1'b1, -32768, 1, 0);
    add_row(0, 0, MODE_PEAK, 1'b1, 16384, 1, -1541);
    add_row(0, 0, MODE_PEAK, 1'b1, 1, 1, -23119);
    add_row(0, 0, MODE_PEAK, 1'b1, 32767, 0, 0);
    add_row(0, 0, MODE_PEAK, 1'b1, -3, 0, 0);
    add_row(0, 0, MODE_SQUARE, 1'b0, -32768, 1, ENV_ONE);
    add_row(0, 0, MODE_SQUARE, 1'b0, 16384, 1, 8192);
    add_row(0, 0, MODE_SQUARE, 1'b0, 181, 1, 0);
    add_row(0, 0, MODE_SQUARE, 1'b0, 12345, 0, 0);
    add_row(0, 0, MODE_ROOT, 1'b0, -20000, 1, 20000);
    add_row(0, 0, MODE_ABS, 1'b0, 20000, 1, 20000);
    add_row(0, 0, MODE_ABS, 1'b0, -32768, 1, ENV_ONE);
    // a full-scale attack or release coefficient: the envelope barely moves that way
    add_row(16'hFFFF, 0, MODE_PEAK, 1'b0, 0, 1, 0);
    add_row(16'hFFFF, 0, MODE_PEAK, 1'b0, 32767, 1, 0);
    add_row(0, 16'hFFFF, MODE_PEAK, 1'b0, 32767, 1, 32767);
    add_row(0, 16'hFFFF, MODE_PEAK, 1'b0, 0, 0, 0);
    add_row(16'h8000, 16'h4000, MODE_SQUARE, 1'b1, -32768, 0, 0);
    add_row(16'h8000, 16'h4000, MODE_SQUARE, 1'b1, 1000, 0, 0);
    add_row(16'h8000, 16'h4000, MODE_SQUARE, 1'b1, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != held_cfg) write_settings(directed_rows[i].cfg);
      send_sample(directed_rows[i].sample, directed_rows[i].known, directed_rows[i].level);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      s.attack_coef  = pick_coef();
      s.release_coef = pick_coef();
      s.detect_mode  = MODE_W'($urandom_range(0, 3));
      s.log_output   = 1'($urandom_range(0, 1));
      write_settings(s);
      idle_en = (ph < N_PHASES - 2);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_SAMPLES; n++) send_sample(pick_sample(), 1'b0, '0);
    end

    in_chan.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("audio_envelope_detector_tb passed");
    end else begin
      $display("audio_envelope_detector_tb failed");
    end
    $finish;
  end

endmodule
